>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the video timing checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("concurrent assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition observed");

`endif

>>> rtl/vtg_pkg.sv
// ----------------------------------------------------------------------------
// vtg_pkg
// Types, constants and the test palette of the video timing generator.
// ----------------------------------------------------------------------------
package vtg_pkg;

  localparam int COUNT_BITS_DEF = 12;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int COLOUR_W       = 12;
  localparam int PAL_W          = 3;
  localparam int IN_DATA_W      = 16;
  localparam int OUT_DATA_W     = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_H_TOTAL        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V_TOTAL        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_PULSE_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_PULSE_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H_ACTIVE_BEGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H_ACTIVE_END   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_V_ACTIVE_BEGIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_V_ACTIVE_END   = 3'd7;

  // Reset values: 640x480 at 60 Hz.
  localparam logic [CFG_W-1:0] RST_H_TOTAL        = 12'd800;
  localparam logic [CFG_W-1:0] RST_V_TOTAL        = 12'd525;
  localparam logic [CFG_W-1:0] RST_H_PULSE_END    = 12'd95;
  localparam logic [CFG_W-1:0] RST_V_PULSE_END    = 12'd1;
  localparam logic [CFG_W-1:0] RST_H_ACTIVE_BEGIN = 12'd143;
  localparam logic [CFG_W-1:0] RST_H_ACTIVE_END   = 12'd783;
  localparam logic [CFG_W-1:0] RST_V_ACTIVE_BEGIN = 12'd34;
  localparam logic [CFG_W-1:0] RST_V_ACTIVE_END   = 12'd514;

  typedef struct packed {
    logic [CFG_W-1:0] h_total;
    logic [CFG_W-1:0] v_total;
    logic [CFG_W-1:0] h_pulse_end;
    logic [CFG_W-1:0] v_pulse_end;
    logic [CFG_W-1:0] h_active_begin;
    logic [CFG_W-1:0] h_active_end;
    logic [CFG_W-1:0] v_active_begin;
    logic [CFG_W-1:0] v_active_end;
  } vtg_cfg_t;

  typedef struct packed {
    logic             hsync;
    logic             vsync;
    logic             blank;
    logic             pixel_request;
    logic [PAL_W-1:0] palette_index;
  } vtg_timing_t;

  // Colour bar palette, red in the low nibble.
  function automatic logic [COLOUR_W-1:0] bar_colour(input logic [PAL_W-1:0] idx);
    logic [COLOUR_W-1:0] c;
    case (idx)
      3'd0:    c = 12'hf00;
      3'd1:    c = 12'h0f0;
      3'd2:    c = 12'h00f;
      3'd3:    c = 12'hff0;
      3'd4:    c = 12'h0ff;
      3'd5:    c = 12'hf0f;
      3'd6:    c = 12'h000;
      3'd7:    c = 12'hfff;
      default: c = 12'h000;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/vga_timing_generator_core.sv
// ----------------------------------------------------------------------------
// vga_timing_generator_core
// VGA sync timing generator with colour pass-through and test bars.
// ----------------------------------------------------------------------------
// Every input transaction is one pixel-clock tick and yields exactly one
// output transaction, so the block sustains one pixel per clock cycle while
// the output is not stalled. An input transaction is taken whenever the
// output register is empty or its content is being taken in the same cycle;
// the result then appears on the output in the next cycle. The counters, the
// palette index and the request flag only move on an accepted tick, so any
// stalling on either side leaves the timing unchanged. Configuration
// registers are written directly from the write port and should only be
// changed while no transaction is in flight.
// ----------------------------------------------------------------------------
module vga_timing_generator_core #(
  parameter int CountBits = vtg_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [vtg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vtg_pkg::CFG_W-1:0]       cfg_data_i,
  // Tick stream in.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [11:0] pixel_word, [12] test_mode, [13] sync_clear, [15:14] zero.
  input  logic [vtg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Pixel stream out.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] red, [7:4] green, [11:8] blue, [12] hsync, [13] vsync,
  // [14] blank, [15] pixel_request.
  output logic [vtg_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import vtg_pkg::*;

  vtg_cfg_t    cfg_q;
  vtg_timing_t timing;

  logic                  accept;
  logic [COLOUR_W-1:0]   pixel_word;
  logic                  test_mode;
  logic                  sync_clear;
  logic [COLOUR_W-1:0]   colour;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Configuration registers, reset to standard 640x480 timing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_total        <= RST_H_TOTAL;
      cfg_q.v_total        <= RST_V_TOTAL;
      cfg_q.h_pulse_end    <= RST_H_PULSE_END;
      cfg_q.v_pulse_end    <= RST_V_PULSE_END;
      cfg_q.h_active_begin <= RST_H_ACTIVE_BEGIN;
      cfg_q.h_active_end   <= RST_H_ACTIVE_END;
      cfg_q.v_active_begin <= RST_V_ACTIVE_BEGIN;
      cfg_q.v_active_end   <= RST_V_ACTIVE_END;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_H_TOTAL:        cfg_q.h_total        <= cfg_data_i;
        REG_V_TOTAL:        cfg_q.v_total        <= cfg_data_i;
        REG_H_PULSE_END:    cfg_q.h_pulse_end    <= cfg_data_i;
        REG_V_PULSE_END:    cfg_q.v_pulse_end    <= cfg_data_i;
        REG_H_ACTIVE_BEGIN: cfg_q.h_active_begin <= cfg_data_i;
        REG_H_ACTIVE_END:   cfg_q.h_active_end   <= cfg_data_i;
        REG_V_ACTIVE_BEGIN: cfg_q.v_active_begin <= cfg_data_i;
        REG_V_ACTIVE_END:   cfg_q.v_active_end   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The output register is refilled in the same cycle it drains.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pixel_word = s_axis_tdata[COLOUR_W-1:0];
  assign test_mode  = s_axis_tdata[COLOUR_W];
  assign sync_clear = s_axis_tdata[COLOUR_W+1];

  vtg_counters #(
    .CountBits (CountBits)
  ) u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .clear_i  (sync_clear),
    .cfg_i    (cfg_q),
    .timing_o (timing)
  );

  // Test mode draws from the bar palette with the index already updated
  // for this tick.
  assign colour = test_mode ? bar_colour(timing.palette_index) : pixel_word;

  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      out_data_d  = {timing.pixel_request, timing.blank, timing.vsync, timing.hsync,
                     colour};
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/vtg_counters.sv
// ----------------------------------------------------------------------------
// vtg_counters
// Horizontal and vertical counters, palette index and request flag.
// ----------------------------------------------------------------------------
module vtg_counters #(
  parameter int CountBits = vtg_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 clear_i,
  input  vtg_pkg::vtg_cfg_t    cfg_i,
  output vtg_pkg::vtg_timing_t timing_o
);
  import vtg_pkg::*;

  // Comparisons run one bit wider than either operand so count+1 never wraps.
  localparam int CmpW = ((CountBits > CFG_W) ? CountBits : CFG_W) + 1;

  logic [CountBits-1:0] h_count_q, h_count_d;
  logic [CountBits-1:0] v_count_q, v_count_d;
  logic [PAL_W-1:0]     pal_q, pal_d;
  logic                 req_q, req_d;

  logic [CmpW-1:0] h_ext, v_ext, h_ahead, v_ahead;
  logic            line_end;

  always_comb begin
    h_ext   = CmpW'(h_count_q);
    v_ext   = CmpW'(v_count_q);
    h_ahead = h_ext + CmpW'(1);
    v_ahead = v_ext + CmpW'(1);

    // Palette steps at the first active pixel of every 32nd line.
    if (clear_i) begin
      pal_d = '0;
    end else if ((v_count_q[4:0] == 5'd0) && (h_ext == CmpW'(cfg_i.h_active_begin)) &&
                 req_q) begin
      pal_d = pal_q + PAL_W'(1);
    end else begin
      pal_d = pal_q;
    end

    req_d = (h_ahead >= CmpW'(cfg_i.h_active_begin)) &&
            (h_ahead <= CmpW'(cfg_i.h_active_end)) &&
            (v_ahead >= CmpW'(cfg_i.v_active_begin)) &&
            (v_ahead <= CmpW'(cfg_i.v_active_end));

    line_end = (h_ahead >= CmpW'(cfg_i.h_total));
    if (clear_i) begin
      h_count_d = '0;
      v_count_d = '0;
    end else if (line_end) begin
      h_count_d = '0;
      v_count_d = (v_ahead >= CmpW'(cfg_i.v_total)) ? '0 : v_ahead[CountBits-1:0];
    end else begin
      h_count_d = h_ahead[CountBits-1:0];
      v_count_d = v_count_q;
    end

    timing_o.hsync         = (h_ext > CmpW'(cfg_i.h_pulse_end));
    timing_o.vsync         = (v_ext > CmpW'(cfg_i.v_pulse_end));
    timing_o.blank         = !clear_i && req_q;
    timing_o.pixel_request = req_d;
    timing_o.palette_index = pal_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_count_q <= '0;
      v_count_q <= '0;
      pal_q     <= '0;
      req_q     <= 1'b0;
    end else if (step_i) begin
      h_count_q <= h_count_d;
      v_count_q <= v_count_d;
      pal_q     <= pal_d;
      req_q     <= req_d;
    end
  end

endmodule

>>> rtl/vtg_checker.sv
// ----------------------------------------------------------------------------
// vtg_checker
// Port-level assertions for the video timing generator, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [vtg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [vtg_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import vtg_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its value.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
               m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // An empty output register never refuses a tick.
  `ASSERT_NEVER(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid && !s_axis_tready)

  // A clearing tick yields its result next cycle with blank low.
  `ASSERT_PROP(a_clear_blank, clk_i, rst_ni,
               in_acc && s_axis_tdata[COLOUR_W+1] |=> m_axis_tvalid && !m_axis_tdata[14])

  // Outside test mode the pixel word passes through unchanged.
  `ASSERT_PROP(a_pass_through, clk_i, rst_ni,
               in_acc && !s_axis_tdata[COLOUR_W] |=>
               m_axis_tvalid && (m_axis_tdata[COLOUR_W-1:0] == $past(s_axis_tdata[COLOUR_W-1:0])))

endmodule

bind vga_timing_generator_core vtg_checker u_vtg_checker (.*);
